// ===== hdl/msb_pkg.sv =====
// Package for the masked sprite blitter: field widths, mode, kind and
// register codes, and the command, status and result structs.
// No dependencies.
package msb_pkg;

  // Default screen geometry and texel store size
  localparam int SCREEN_WIDTH_DEF  = 160;
  localparam int SCREEN_HEIGHT_DEF = 120;
  localparam int TEXEL_BYTES_DEF   = 4096;

  // Field widths
  localparam int MODE_W     = 2;
  localparam int SLOT_W     = 4;
  localparam int COLOR_W    = 16;
  localparam int TADDR_W    = 12;
  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 2;
  localparam int ADDR_W     = 15;
  localparam int COUNT_W    = 17;
  localparam int REG_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Internal widths
  localparam int COORD_W    = 12;   // signed screen coordinate, covers origin + 510
  localparam int NIB_W      = 4;
  localparam int PAL_DEPTH  = 16;
  localparam int BIT_W      = 3;    // bit position inside a mask byte
  localparam int BYTE_IDX_W = 5;    // mask byte inside a column
  localparam int PITCH_W    = 6;    // mask bytes per column, up to 32
  localparam int MAX_HEIGHT = 256;

  localparam logic [BIT_W-1:0] BIT_LAST = 3'd7;

  // Input modes
  localparam logic [MODE_W-1:0] MODE_PALETTE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TEXEL   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MASK    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_START   = 2'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HGT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COUNT = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic             accept;    // input transfer this cycle
    logic             prep;      // load per-byte screen position
    logic             step;      // process one mask bit
    logic             end_byte;  // advance byte / column, maybe end frame
    logic             flush;     // release held result as last
    logic [BIT_W-1:0] bit_idx;
  } msb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk_req;   // offered item is a mask byte of a running frame
    logic bit_err;    // current bit overruns the active count
    logic out_free;   // output register can take a result this cycle
  } msb_status_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic [COUNT_W-1:0] count;
  } msb_result_t;

endpackage

// ===== hdl/msb_if.sv =====
// Channel interfaces for the masked sprite blitter: input items and results.
// Depends on msb_pkg.
interface msb_item_if import msb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [SLOT_W-1:0]   palette_slot;
  logic [COLOR_W-1:0]  palette_color;
  logic [TADDR_W-1:0]  texel_address;
  logic [BYTE_W-1:0]   data_byte;

  modport source (output valid, mode, palette_slot, palette_color, texel_address,
                  data_byte, input ready);
  modport sink   (input valid, mode, palette_slot, palette_color, texel_address,
                  data_byte, output ready);
endinterface

interface msb_result_if import msb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [ADDR_W-1:0]   pixel_address;
  logic [COLOR_W-1:0]  pixel_color;
  logic [COUNT_W-1:0]  drawn_count;
  logic                last;

  modport source (output valid, kind, pixel_address, pixel_color, drawn_count, last,
                  input ready);
  modport sink   (input valid, kind, pixel_address, pixel_color, drawn_count, last,
                  output ready);
endinterface

// ===== hdl/msb_ctrl.sv =====
// Controller for the masked sprite blitter: sequences a mask byte through prepare,
// eight bit steps, byte end and flush; an error bit flushes early. Depends on msb_pkg.
module msb_ctrl import msb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  msb_status_t st,
  output msb_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_END   = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0]       state, state_next;
  logic [BIT_W-1:0] bit_idx, bit_idx_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next   = state;
    bit_idx_next = bit_idx;
    cmd          = '0;
    cmd.bit_idx  = bit_idx;
    unique case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && st.walk_req) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep     = 1'b1;
        bit_idx_next = '0;
        state_next   = S_WALK;
      end
      S_WALK: begin
        if (st.out_free) begin
          cmd.step = 1'b1;
          if (st.bit_err) begin
            state_next = S_FLUSH;
          end else if (bit_idx == BIT_LAST) begin
            state_next = S_END;
          end else begin
            bit_idx_next = bit_idx + BIT_W'(1);
          end
        end
      end
      S_END: begin
        if (st.out_free) begin
          cmd.end_byte = 1'b1;
          state_next   = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (st.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      bit_idx <= '0;
    end else begin
      state   <= state_next;
      bit_idx <= bit_idx_next;
    end
  end

  // Every byte walk starts at bit position 0
  a_prep_to_walk: assert property (@(posedge clk) disable iff (rst)
    state == S_PREP |=> (state == S_WALK && bit_idx == '0))
    else $error("byte walk did not start at bit 0");

  // Input side reopens only after a flush
  a_ready_after_flush: assert property (@(posedge clk) disable iff (rst)
    $rose(in_ready) |-> $past(state) == S_FLUSH)
    else $error("input ready rose outside flush");

  // A clean step moves to the next bit
  a_bit_advance: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && cmd.step && !st.bit_err && bit_idx != BIT_LAST)
      |=> (state == S_WALK && bit_idx == BIT_W'($past(bit_idx) + 1'b1)))
    else $error("bit position skipped");

endmodule

// ===== hdl/msb_datapath.sv =====
// Datapath for the masked sprite blitter: config registers, palette, texel
// memory, walk counters, pixel address math and the result hold/output stage.
// Depends on msb_pkg and msb_if.
module msb_datapath import msb_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int TEXEL_BYTES   = TEXEL_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  msb_item_if.sink              item,
  msb_result_if.source          result,
  input  msb_cmd_t              cmd,
  output msb_status_t           st
);

  localparam int TIDX_W    = $clog2(TEXEL_BYTES);
  localparam int FB_PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam bit FB_FITS   = FB_PIXELS <= (1 << ADDR_W);

  // Configuration registers
  logic signed [REG_W-1:0] origin_x, origin_y;
  logic [REG_W-1:0]        sprite_width, sprite_height;
  logic [COUNT_W-1:0]      active_pixel_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x           <= '0;
      origin_y           <= '0;
      sprite_width       <= REG_W'(1);
      sprite_height      <= REG_W'(1);
      active_pixel_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X:     origin_x <= $signed(cfg_data[REG_W-1:0]);
        REG_ORIGIN_Y:     origin_y <= $signed(cfg_data[REG_W-1:0]);
        REG_SPRITE_WIDTH: sprite_width <= cfg_data[REG_W-1:0];
        REG_SPRITE_HGT:   sprite_height <= cfg_data[REG_W-1:0];
        REG_ACTIVE_COUNT: active_pixel_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic load_palette, load_texel, start_frame;
  assign load_palette = cmd.accept && (item.mode == MODE_PALETTE);
  assign load_texel   = cmd.accept && (item.mode == MODE_TEXEL) &&
                        (COUNT_W'(item.texel_address) < COUNT_W'(TEXEL_BYTES));
  assign start_frame  = cmd.accept && (item.mode == MODE_START);

  // Palette flops
  logic [COLOR_W-1:0] palette [PAL_DEPTH];

  always_ff @(posedge clk) begin
    if (load_palette) begin
      palette[item.palette_slot] <= item.palette_color;
    end
  end

  // Walk state
  logic [REG_W-1:0]      column_index, col_next;
  logic [BYTE_IDX_W-1:0] byte_in_column, byte_next;
  logic [COUNT_W-1:0]    active_index, act_next;
  logic                  frame_stopped, stop_next;
  logic [BYTE_W-1:0]     mask_byte;

  // Texel memory; read tracks the next active index so data lines up
  logic [BYTE_W-1:0]      texel_mem [TEXEL_BYTES];
  logic [BYTE_W-1:0]      rd_byte;
  logic                   rd_oob;
  logic [COUNT_W-2:0]     rd_byte_sel;
  logic [TIDX_W-1:0]      rd_idx;

  assign rd_byte_sel = act_next[COUNT_W-1:1];
  assign rd_idx      = TIDX_W'(rd_byte_sel);

  always_ff @(posedge clk) begin
    if (load_texel) begin
      texel_mem[TIDX_W'(item.texel_address)] <= item.data_byte;
    end
    rd_byte <= texel_mem[rd_idx];
    rd_oob  <= COUNT_W'(rd_byte_sel) >= COUNT_W'(TEXEL_BYTES);
  end

  // Screen position of the current byte, two register stages
  logic signed [COORD_W-1:0] xr, yr, ycur;
  logic [ADDR_W-1:0]         addr_cur, base_addr;
  logic                      x_on;

  assign base_addr = ADDR_W'(ADDR_W'(yr) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(xr));

  always_ff @(posedge clk) begin
    xr <= COORD_W'(origin_x) + $signed(COORD_W'(column_index));
    yr <= COORD_W'(origin_y) + $signed(COORD_W'({byte_in_column, 3'b000}));
    if (cmd.prep) begin
      ycur     <= yr;
      addr_cur <= base_addr;
      x_on     <= (xr >= 0) && (xr < $signed(COORD_W'(SCREEN_WIDTH)));
    end else if (cmd.step) begin
      ycur     <= ycur + COORD_W'(1);
      addr_cur <= addr_cur + ADDR_W'(SCREEN_WIDTH);
    end
  end

  // Per-bit decode
  logic [REG_W-1:0]   h_eff;
  logic [7:0]         row;
  logic               bit_valid, err_now, y_on;
  logic [BYTE_W-1:0]  texel;
  logic [NIB_W-1:0]   nibble;
  logic [COLOR_W-1:0] color;
  logic [COUNT_W-1:0] cnt_inc;

  assign h_eff     = (sprite_height > REG_W'(MAX_HEIGHT)) ? REG_W'(MAX_HEIGHT) : sprite_height;
  assign row       = {byte_in_column, cmd.bit_idx};
  assign bit_valid = mask_byte[cmd.bit_idx] && (REG_W'(row) < h_eff);
  assign err_now   = bit_valid && (active_index >= active_pixel_count);
  assign y_on      = (ycur >= 0) && (ycur < $signed(COORD_W'(SCREEN_HEIGHT)));
  assign texel     = rd_oob ? '0 : rd_byte;
  assign nibble    = active_index[0] ? texel[7:4] : texel[3:0];
  assign color     = palette[nibble];
  assign cnt_inc   = active_index + COUNT_W'(1);

  // Byte and column end
  logic [PITCH_W-1:0] pitch_raw, pitch, byte_inc;
  logic [REG_W-1:0]   col_inc;
  logic               byte_wrap, frame_end;

  assign pitch_raw = PITCH_W'((10'(h_eff) + 10'd7) >> 3);
  assign pitch     = (pitch_raw == '0) ? PITCH_W'(1) : pitch_raw;
  assign byte_inc  = PITCH_W'(byte_in_column) + PITCH_W'(1);
  assign byte_wrap = byte_inc >= pitch;
  assign col_inc   = column_index + REG_W'(1);
  assign frame_end = (col_inc >= sprite_width) || (col_inc == '0);

  // Next walk state and new result
  logic        new_valid;
  msb_result_t new_res;

  always_comb begin
    col_next  = column_index;
    byte_next = byte_in_column;
    act_next  = active_index;
    stop_next = frame_stopped;
    new_valid = 1'b0;
    new_res   = '0;
    if (start_frame) begin
      col_next  = '0;
      byte_next = '0;
      act_next  = '0;
      stop_next = 1'b0;
    end
    if (cmd.step && bit_valid) begin
      if (err_now) begin
        stop_next     = 1'b1;
        new_valid     = 1'b1;
        new_res.kind  = KIND_ERROR;
        new_res.count = active_index;
      end else begin
        act_next = cnt_inc;
        if (x_on && y_on) begin
          new_valid     = 1'b1;
          new_res.kind  = KIND_PIXEL;
          new_res.addr  = addr_cur;
          new_res.color = color;
          new_res.count = cnt_inc;
        end
      end
    end
    if (cmd.end_byte) begin
      if (byte_wrap) begin
        byte_next = '0;
        col_next  = col_inc;
        if (frame_end) begin
          stop_next     = 1'b1;
          new_valid     = 1'b1;
          new_res.kind  = (active_index == active_pixel_count) ? KIND_DONE : KIND_ERROR;
          new_res.count = active_index;
        end
      end else begin
        byte_next = byte_inc[BYTE_IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index   <= '0;
      byte_in_column <= '0;
      active_index   <= '0;
      frame_stopped  <= 1'b0;
    end else begin
      column_index   <= col_next;
      byte_in_column <= byte_next;
      active_index   <= act_next;
      frame_stopped  <= stop_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (item.mode == MODE_MASK)) begin
      mask_byte <= item.data_byte;
    end
  end

  // Result hold stage: one result waits until it is known whether it is last
  logic        hold_valid, out_valid, out_last, out_load;
  msb_result_t hold_res, out_res;

  assign out_load = hold_valid && (new_valid || cmd.flush);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (new_valid) begin
        hold_valid <= 1'b1;
      end else if (cmd.flush) begin
        hold_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (new_valid) begin
      hold_res <= new_res;
    end
    if (out_load) begin
      out_res  <= hold_res;
      out_last <= cmd.flush;
    end
  end

  // Output channel
  assign result.valid         = out_valid;
  assign result.kind          = out_res.kind;
  assign result.pixel_address = out_res.addr;
  assign result.pixel_color   = out_res.color;
  assign result.drawn_count   = out_res.count;
  assign result.last          = out_last;

  // Status to controller
  assign st.walk_req = (item.mode == MODE_MASK) && !frame_stopped;
  assign st.bit_err  = err_now;
  assign st.out_free = !out_valid || result.ready;

  // Flush always empties the hold stage
  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> !hold_valid)
    else $error("hold stage not empty after flush");

  // A stopped frame stays stopped until a start frame transfer
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    (frame_stopped && !start_frame) |=> frame_stopped)
    else $error("frame restarted without start frame");

  // Pixel writes land inside the framebuffer
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.kind == KIND_PIXEL)
      |-> (!FB_FITS || (32'(out_res.addr) < 32'(FB_PIXELS))))
    else $error("pixel address outside framebuffer");

endmodule

// ===== hdl/masked_sprite_blitter.sv =====
// Top level of the masked sprite blitter: controller plus datapath.
// Depends on msb_pkg, msb_if, msb_ctrl and msb_datapath.
//
// Palette words, texel bytes and start frame are taken without leaving the
// idle state. A mask byte of a running frame holds off the next input
// transfer until it has gone through a position setup step, eight bit
// steps of the bit sequencer (one mask bit each, one texel nibble and palette
// lookup per step from the registered texel memory read), a byte/column end
// step and a flush step that marks the final result with last; an error bit
// skips straight to the flush. Bit steps, byte end and flush pause while the
// result register is full and not being taken. Mask bytes after a done or
// error result are taken without a walk and produce nothing until the next
// start frame. Texel memory and palette need no clearing pass after reset.
module masked_sprite_blitter import msb_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int TEXEL_BYTES   = TEXEL_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  msb_item_if.sink              item,
  msb_result_if.source          result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  msb_cmd_t    cmd;
  msb_status_t st;
  logic        item_ready;

  assign item.ready = item_ready;

  // Sequencer
  msb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Storage, arithmetic and result stage
  msb_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .TEXEL_BYTES   (TEXEL_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .result    (result),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
